// File: rtl/clfp_pkg.sv
// ----------------------------------------------------------------------------
// clfp_pkg
// shared types and constants of the contact list frame parser
// ----------------------------------------------------------------------------
package clfp_pkg;

   localparam int MAX_CONTACTS_DEF = 8;
   localparam int LABEL_CAP_DEF    = 16;
   localparam int FOOTER_CAP_DEF   = 32;
   localparam int QUEUE_DEPTH      = 4;
   localparam int HEADER_BYTES     = 3;

   typedef enum logic [1:0] {
      PH_COUNT,
      PH_HEADER,
      PH_LABEL,
      PH_FOOTER
   } phase_type;

   typedef enum logic [1:0] {
      ST_NONE,
      ST_ACCEPTED,
      ST_TRUNCATED,
      ST_TOO_LONG
   } status_type;

   // classified request as it travels from front to back
   typedef struct packed {
      logic       is_read;
      logic       entry_in_range;
      logic       footer_sel;
      logic [7:0] data_byte;
      logic       last_byte;
      logic [3:0] entry_index;
      logic [4:0] char_index;
   } cmd_type;

   typedef struct packed {
      logic [1:0] frame_status;
      logic       set_valid;
      logic [3:0] contact_count;
      logic [7:0] bearing;
      logic [7:0] range_value;
      logic [7:0] contact_flags;
      logic [4:0] text_length;
      logic [7:0] text_char;
   } rsp_type;

endpackage

// File: rtl/clfp_fifo.sv
// ----------------------------------------------------------------------------
// clfp_fifo
// small register queue with occupancy count
// ----------------------------------------------------------------------------
module clfp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = clfp_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(DEPTH));
   assign count   = count_ff;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/clfp_front.sv
// ----------------------------------------------------------------------------
// clfp_front
// accepts request transactions and classifies them
// ----------------------------------------------------------------------------
module clfp_front #(
   parameter int MAX_CONTACTS = clfp_pkg::MAX_CONTACTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_op,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   input  logic [3:0]        req_entry_index,
   input  logic [4:0]        req_char_index,
   output logic              cmd_valid,
   output clfp_pkg::cmd_type cmd,
   input  logic              cmd_full
);
   logic              valid_ff, valid_in;
   clfp_pkg::cmd_type cmd_ff, cmd_in;
   logic              take, hand_off;

   assign hand_off  = valid_ff && !cmd_full;
   assign req_full  = valid_ff && cmd_full;
   assign take      = req_push && !req_full;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      valid_in              = (valid_ff && !hand_off) || take;
      cmd_in.is_read        = req_op;
      cmd_in.entry_in_range = (req_entry_index < 4'(MAX_CONTACTS));
      cmd_in.footer_sel     = (req_entry_index == 4'(MAX_CONTACTS));
      cmd_in.data_byte      = req_data_byte;
      cmd_in.last_byte      = req_last_byte;
      cmd_in.entry_index    = req_entry_index;
      cmd_in.char_index     = req_char_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// File: rtl/clfp_back.sv
// ----------------------------------------------------------------------------
// clfp_back
// frame parser, double banked contact store and read path
// ----------------------------------------------------------------------------
module clfp_back #(
   parameter int MAX_CONTACTS = clfp_pkg::MAX_CONTACTS_DEF,
   parameter int LABEL_CAP    = clfp_pkg::LABEL_CAP_DEF,
   parameter int FOOTER_CAP   = clfp_pkg::FOOTER_CAP_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  clfp_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              out_room,
   output logic              rsp_valid,
   output clfp_pkg::rsp_type rsp
);
   localparam int LBL_MAX = LABEL_CAP - 1;
   localparam int FTR_MAX = FOOTER_CAP - 1;
   localparam int SLOTS   = 2 * MAX_CONTACTS;
   localparam int SL_W    = $clog2(SLOTS);
   localparam int LC_DEP  = SLOTS * LBL_MAX;
   localparam int LA_W    = (LC_DEP > 1) ? $clog2(LC_DEP) : 1;
   localparam int FC_DEP  = 2 * FTR_MAX;
   localparam int FA_W    = (FC_DEP > 1) ? $clog2(FC_DEP) : 1;
   localparam int LL_W    = $clog2(LABEL_CAP);
   localparam int FL_W    = $clog2(FOOTER_CAP);
   localparam int CW_W    = (LL_W > FL_W) ? LL_W : FL_W;

   // stores
   logic [7:0]      bear_mem [SLOTS];
   logic [7:0]      rng_mem [SLOTS];
   logic [7:0]      flg_mem [SLOTS];
   logic [LL_W-1:0] len_mem [SLOTS];
   logic [7:0]      lchar_mem [LC_DEP];
   logic [7:0]      fchar_mem [FC_DEP];

   // parser state
   clfp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]      fbc_ff, fbc_in;
   logic            ovl_ff, ovl_in;
   logic [3:0]      decl_ff, decl_in;
   logic [3:0]      cur_ff, cur_in;
   logic [1:0]      hpos_ff, hpos_in;
   logic [7:0]      left_ff, left_in;
   logic [CW_W-1:0] cw_ff, cw_in;
   logic            bank_ff, bank_in;
   logic [3:0]      cnt_ff [2];
   logic [3:0]      cnt_in [2];
   logic [FL_W-1:0] flen_ff [2];
   logic [FL_W-1:0] flen_in [2];
   logic            cval_ff, cval_in;

   // store writes
   logic            we_bear, we_rng, we_flg, we_len, we_lchar, we_fchar;
   logic [SL_W-1:0] wslot;
   logic [LL_W-1:0] wlen;
   logic [LA_W-1:0] wl_addr;
   logic [FA_W-1:0] wf_addr;

   // read side
   logic            fire, push_op;
   logic [1:0]      status;
   logic            rd_contact, rd_footer;
   logic [SL_W-1:0] rslot;
   logic [LA_W-1:0] rl_addr;
   logic [FA_W-1:0] rf_addr;
   logic [3:0]      rd_cnt;

   // second stage
   logic            b_valid_ff;
   logic            b_contact_ff, b_footer_ff;
   logic [4:0]      b_ci_ff;
   logic [FL_W-1:0] b_flen_ff;
   logic [1:0]      b_status_ff;
   logic            b_sv_ff;
   logic [3:0]      b_cnt_ff;
   logic [7:0]      b_bear_ff, b_rng_ff, b_flg_ff, b_lchar_ff, b_fchar_ff;
   logic [LL_W-1:0] b_len_ff;

   assign fire    = cmd_valid && out_room;
   assign cmd_pop = fire;
   assign push_op = fire && !cmd.is_read;

   always_comb begin
      logic       sh;
      logic       taking;
      logic [3:0] cur_next;
      phase_in = phase_ff;
      fbc_in   = fbc_ff;
      ovl_in   = ovl_ff;
      decl_in  = decl_ff;
      cur_in   = cur_ff;
      hpos_in  = hpos_ff;
      left_in  = left_ff;
      cw_in    = cw_ff;
      bank_in  = bank_ff;
      cnt_in   = cnt_ff;
      flen_in  = flen_ff;
      cval_in  = cval_ff;
      status   = clfp_pkg::ST_NONE;
      we_bear  = 1'b0;
      we_rng   = 1'b0;
      we_flg   = 1'b0;
      we_len   = 1'b0;
      we_lchar = 1'b0;
      we_fchar = 1'b0;
      taking   = 1'b0;
      sh       = ~bank_ff;
      cur_next = cur_ff + 1'b1;
      wslot    = sh ? SL_W'(MAX_CONTACTS + int'(cur_ff)) : SL_W'(cur_ff);
      wlen     = (cmd.data_byte < 8'(LBL_MAX)) ? cmd.data_byte[LL_W-1:0] : LL_W'(LBL_MAX);
      wl_addr  = LA_W'(int'(wslot) * LBL_MAX + int'(cw_ff));
      wf_addr  = FA_W'(int'(sh) * FTR_MAX + int'(cw_ff));
      if (push_op) begin
         if (fbc_ff == 8'hff) begin
            ovl_in = 1'b1;
         end else begin
            fbc_in = fbc_ff + 1'b1;
         end
         taking = !ovl_in;
         if (taking) begin
            unique case (phase_ff)
               clfp_pkg::PH_COUNT: begin
                  decl_in  = (cmd.data_byte > 8'(MAX_CONTACTS)) ? 4'(MAX_CONTACTS)
                                                                : cmd.data_byte[3:0];
                  cur_in   = '0;
                  hpos_in  = '0;
                  cw_in    = '0;
                  phase_in = (decl_in == '0) ? clfp_pkg::PH_FOOTER : clfp_pkg::PH_HEADER;
               end
               clfp_pkg::PH_HEADER: begin
                  if (int'(hpos_ff) < clfp_pkg::HEADER_BYTES) begin
                     we_bear = (hpos_ff == 2'd0);
                     we_rng  = (hpos_ff == 2'd1);
                     we_flg  = (hpos_ff == 2'd2);
                     hpos_in = hpos_ff + 1'b1;
                  end else begin
                     left_in = cmd.data_byte;
                     we_len  = 1'b1;
                     cw_in   = '0;
                     if (cmd.data_byte == 8'd0) begin
                        cur_in   = cur_next;
                        hpos_in  = '0;
                        phase_in = (cur_next >= decl_ff) ? clfp_pkg::PH_FOOTER
                                                         : clfp_pkg::PH_HEADER;
                     end else begin
                        phase_in = clfp_pkg::PH_LABEL;
                     end
                  end
               end
               clfp_pkg::PH_LABEL: begin
                  if (int'(cw_ff) < LBL_MAX) begin
                     we_lchar = 1'b1;
                     cw_in    = cw_ff + 1'b1;
                  end
                  if (left_ff != 8'd0) begin
                     left_in = left_ff - 1'b1;
                  end
                  if (left_in == 8'd0) begin
                     cur_in   = cur_next;
                     cw_in    = '0;
                     hpos_in  = '0;
                     phase_in = (cur_next >= decl_ff) ? clfp_pkg::PH_FOOTER
                                                      : clfp_pkg::PH_HEADER;
                  end
               end
               clfp_pkg::PH_FOOTER: begin
                  if (int'(cw_ff) < FTR_MAX) begin
                     we_fchar = 1'b1;
                     cw_in    = cw_ff + 1'b1;
                  end
               end
               default: begin
                  phase_in = clfp_pkg::PH_COUNT;
               end
            endcase
         end
         if (cmd.last_byte) begin
            priority if (ovl_in) begin
               status = clfp_pkg::ST_TOO_LONG;
            end else if (phase_in != clfp_pkg::PH_FOOTER) begin
               status = clfp_pkg::ST_TRUNCATED;
            end else begin
               cnt_in[sh]  = decl_in;
               flen_in[sh] = FL_W'(cw_in);
               bank_in     = sh;
               cval_in     = 1'b1;
               status      = clfp_pkg::ST_ACCEPTED;
            end
            phase_in = clfp_pkg::PH_COUNT;
            fbc_in   = '0;
            ovl_in   = 1'b0;
            decl_in  = '0;
            cur_in   = '0;
            hpos_in  = '0;
            left_in  = '0;
            cw_in    = '0;
         end
      end
   end

   // read addresses into the committed bank
   always_comb begin
      rd_cnt     = cnt_ff[bank_ff];
      rd_contact = cmd.is_read && cmd.entry_in_range && (cmd.entry_index < rd_cnt);
      rd_footer  = cmd.is_read && cmd.footer_sel;
      rslot      = bank_ff ? SL_W'(MAX_CONTACTS + int'(cmd.entry_index))
                           : SL_W'(cmd.entry_index);
      rl_addr    = (int'(cmd.char_index) < LBL_MAX)
                   ? LA_W'(int'(rslot) * LBL_MAX + int'(cmd.char_index)) : '0;
      rf_addr    = (int'(cmd.char_index) < FTR_MAX)
                   ? FA_W'(int'(bank_ff) * FTR_MAX + int'(cmd.char_index)) : '0;
   end

   always_ff @(posedge clock) begin
      if (we_bear) begin
         bear_mem[wslot] <= cmd.data_byte;
      end
      if (we_rng) begin
         rng_mem[wslot] <= cmd.data_byte;
      end
      if (we_flg) begin
         flg_mem[wslot] <= cmd.data_byte;
      end
      if (we_len) begin
         len_mem[wslot] <= wlen;
      end
      if (we_lchar) begin
         lchar_mem[wl_addr] <= cmd.data_byte;
      end
      if (we_fchar) begin
         fchar_mem[wf_addr] <= cmd.data_byte;
      end
      if (fire) begin
         b_bear_ff  <= bear_mem[rslot];
         b_rng_ff   <= rng_mem[rslot];
         b_flg_ff   <= flg_mem[rslot];
         b_len_ff   <= len_mem[rslot];
         b_lchar_ff <= lchar_mem[rl_addr];
         b_fchar_ff <= fchar_mem[rf_addr];
         b_ci_ff    <= cmd.char_index;
         b_flen_ff  <= flen_ff[bank_ff];
         b_status_ff <= status;
         b_sv_ff    <= cval_in;
         b_cnt_ff   <= cnt_in[bank_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= clfp_pkg::PH_COUNT;
         fbc_ff       <= '0;
         ovl_ff       <= 1'b0;
         decl_ff      <= '0;
         cur_ff       <= '0;
         hpos_ff      <= '0;
         left_ff      <= '0;
         cw_ff        <= '0;
         bank_ff      <= 1'b0;
         cnt_ff       <= '{default: '0};
         flen_ff      <= '{default: '0};
         cval_ff      <= 1'b0;
         b_valid_ff   <= 1'b0;
         b_contact_ff <= 1'b0;
         b_footer_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         fbc_ff     <= fbc_in;
         ovl_ff     <= ovl_in;
         decl_ff    <= decl_in;
         cur_ff     <= cur_in;
         hpos_ff    <= hpos_in;
         left_ff    <= left_in;
         cw_ff      <= cw_in;
         bank_ff    <= bank_in;
         cnt_ff     <= cnt_in;
         flen_ff    <= flen_in;
         cval_ff    <= cval_in;
         b_valid_ff <= fire;
         if (fire) begin
            b_contact_ff <= rd_contact;
            b_footer_ff  <= rd_footer;
         end
      end
   end

   // result assembly
   always_comb begin
      rsp               = '0;
      rsp.frame_status  = b_status_ff;
      rsp.set_valid     = b_sv_ff;
      rsp.contact_count = b_cnt_ff;
      if (b_contact_ff) begin
         rsp.bearing       = b_bear_ff;
         rsp.range_value   = b_rng_ff;
         rsp.contact_flags = b_flg_ff;
         rsp.text_length   = 5'(b_len_ff);
         if (int'(b_ci_ff) < int'(b_len_ff) && int'(b_ci_ff) < LBL_MAX) begin
            rsp.text_char = b_lchar_ff;
         end
      end else if (b_footer_ff) begin
         rsp.text_length = 5'(b_flen_ff);
         if (int'(b_ci_ff) < int'(b_flen_ff) && int'(b_ci_ff) < FTR_MAX) begin
            rsp.text_char = b_fchar_ff;
         end
      end
   end

   assign rsp_valid = b_valid_ff;

endmodule

// File: rtl/contact_list_frame_parser.sv
// ----------------------------------------------------------------------------
// contact_list_frame_parser
// parses contact list frames byte by byte into a shadow bank, swaps banks on
// a complete frame and answers reads of the committed contact set
// ----------------------------------------------------------------------------
//  channel   ports                        transfer
//  request   req_push / req_full          push & !full, one byte or one read
//  response  rsp_pop / rsp_empty          pop & !empty, one result per request
//
// one transaction per cycle sustained while the receiver keeps popping; a
// request's result is waiting once it has passed the front register, command
// queue, parser step with registered store read and response queue
// reset is synchronous and clears the parser, the bank counts and the valid flag
// the front and the parser stall independently through the command queue; the
// parser only takes a command when the response queue has a free slot
module contact_list_frame_parser #(
   parameter int MAX_CONTACTS = clfp_pkg::MAX_CONTACTS_DEF,
   parameter int LABEL_CAP    = clfp_pkg::LABEL_CAP_DEF,
   parameter int FOOTER_CAP   = clfp_pkg::FOOTER_CAP_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_op,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic [3:0] req_entry_index,
   input  logic [4:0] req_char_index,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_frame_status,
   output logic       rsp_set_valid,
   output logic [3:0] rsp_contact_count,
   output logic [7:0] rsp_bearing,
   output logic [7:0] rsp_range_value,
   output logic [7:0] rsp_contact_flags,
   output logic [4:0] rsp_text_length,
   output logic [7:0] rsp_text_char
);
   localparam int QCW = $clog2(clfp_pkg::QUEUE_DEPTH + 1);

   // front to command queue
   logic              f_valid;
   clfp_pkg::cmd_type f_cmd;
   logic              cq_full, cq_empty;
   logic [QCW-1:0]    cq_count;
   clfp_pkg::cmd_type cq_cmd;
   logic              cq_pop;

   // parser to response queue
   logic              b_valid;
   clfp_pkg::rsp_type b_rsp, rq_rsp;
   logic              rq_full;
   logic [QCW-1:0]    rq_count;
   logic              out_room;

   clfp_front #(.MAX_CONTACTS(MAX_CONTACTS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .req_entry_index (req_entry_index),
      .req_char_index  (req_char_index),
      .cmd_valid       (f_valid),
      .cmd             (f_cmd),
      .cmd_full        (cq_full)
   );

   clfp_fifo #(.WIDTH($bits(clfp_pkg::cmd_type)), .DEPTH(clfp_pkg::QUEUE_DEPTH)) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (f_valid),
      .wr_data (f_cmd),
      .pop     (cq_pop),
      .rd_data (cq_cmd),
      .empty   (cq_empty),
      .full    (cq_full),
      .count   (cq_count)
   );

   // a slot must be free for the result in flight and the one being started
   assign out_room = ({1'b0, rq_count} + {{QCW{1'b0}}, b_valid})
                     < (QCW+1)'(clfp_pkg::QUEUE_DEPTH) && (cq_count != '0);

   clfp_back #(
      .MAX_CONTACTS (MAX_CONTACTS),
      .LABEL_CAP    (LABEL_CAP),
      .FOOTER_CAP   (FOOTER_CAP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cq_empty),
      .cmd       (cq_cmd),
      .cmd_pop   (cq_pop),
      .out_room  (out_room),
      .rsp_valid (b_valid),
      .rsp       (b_rsp)
   );

   clfp_fifo #(.WIDTH($bits(clfp_pkg::rsp_type)), .DEPTH(clfp_pkg::QUEUE_DEPTH)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (b_valid),
      .wr_data (b_rsp),
      .pop     (rsp_pop),
      .rd_data (rq_rsp),
      .empty   (rsp_empty),
      .full    (rq_full),
      .count   (rq_count)
   );

   // rq_full never blocks a push: room is reserved before a command starts
   assign rsp_frame_status  = rq_rsp.frame_status;
   assign rsp_set_valid     = rq_rsp.set_valid;
   assign rsp_contact_count = rq_rsp.contact_count;
   assign rsp_bearing       = rq_rsp.bearing;
   assign rsp_range_value   = rq_rsp.range_value;
   assign rsp_contact_flags = rq_rsp.contact_flags;
   assign rsp_text_length   = rq_rsp.text_length;
   assign rsp_text_char     = rq_rsp.text_char;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contact list frame parser testbench
// feeds frame bytes and reads of the committed set through the request
// queue, predicts every response with a local parser model and checks each
// popped response field by field; both sides idle in random bursts
// ----------------------------------------------------------------------------
module testbench;

   localparam int NCON      = clfp_pkg::MAX_CONTACTS_DEF;
   localparam int LBL_MAX   = clfp_pkg::LABEL_CAP_DEF - 1;
   localparam int FTR_MAX   = clfp_pkg::FOOTER_CAP_DEF - 1;
   localparam int CYCLE_CAP = 600000;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_READ = 1'b1;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic       req_op = OP_PUSH;
   logic [7:0] req_data_byte = '0;
   logic       req_last_byte = 1'b0;
   logic [3:0] req_entry_index = '0;
   logic [4:0] req_char_index = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [1:0] rsp_frame_status;
   logic       rsp_set_valid;
   logic [3:0] rsp_contact_count;
   logic [7:0] rsp_bearing;
   logic [7:0] rsp_range_value;
   logic [7:0] rsp_contact_flags;
   logic [4:0] rsp_text_length;
   logic [7:0] rsp_text_char;

   contact_list_frame_parser i_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   // parser state, a copy of what the block keeps
   clfp_pkg::phase_type mdl_phase;
   int unsigned mdl_byte_count;
   bit          mdl_overlong;
   int unsigned mdl_declared;
   int unsigned mdl_cursor;
   int unsigned mdl_hdr_pos;
   int unsigned mdl_label_left;
   int unsigned mdl_chars;
   bit          mdl_bank;
   logic [7:0]  mdl_records [2*NCON][3];
   logic [3:0]  mdl_label_len [2*NCON];
   logic [7:0]  mdl_label_chars [2*NCON*LBL_MAX];
   logic [7:0]  mdl_footer_chars [2*FTR_MAX];
   logic [4:0]  mdl_footer_len [2];
   logic [3:0]  mdl_bank_count [2];
   bit          mdl_valid;

   clfp_pkg::rsp_type expected_rsps[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          idle_enable = 1'b1;
   logic [7:0]  frame_bytes[$];

   function automatic void restart_parser();
      mdl_phase      = clfp_pkg::PH_COUNT;
      mdl_byte_count = 0;
      mdl_overlong   = 0;
      mdl_declared   = 0;
      mdl_cursor     = 0;
      mdl_hdr_pos    = 0;
      mdl_label_left = 0;
      mdl_chars      = 0;
   endfunction

   function automatic void finish_contact();
      mdl_cursor++;
      mdl_chars   = 0;
      mdl_hdr_pos = 0;
      mdl_phase   = (mdl_cursor >= mdl_declared) ? clfp_pkg::PH_FOOTER : clfp_pkg::PH_HEADER;
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      int unsigned shadow;
      int unsigned slot;
      shadow = !mdl_bank;
      slot   = shadow * NCON + (mdl_cursor % NCON);
      case (mdl_phase)
         clfp_pkg::PH_COUNT: begin
            mdl_declared = (b > NCON) ? NCON : b;
            mdl_cursor   = 0;
            mdl_hdr_pos  = 0;
            mdl_chars    = 0;
            mdl_phase    = (mdl_declared == 0) ? clfp_pkg::PH_FOOTER : clfp_pkg::PH_HEADER;
         end
         clfp_pkg::PH_HEADER: begin
            if (mdl_hdr_pos < clfp_pkg::HEADER_BYTES) begin
               mdl_records[slot][mdl_hdr_pos] = b;
               mdl_hdr_pos++;
            end else begin
               mdl_label_left      = b;
               mdl_label_len[slot] = 4'((b < LBL_MAX) ? b : LBL_MAX);
               mdl_chars           = 0;
               if (b == 0) finish_contact();
               else mdl_phase = clfp_pkg::PH_LABEL;
            end
         end
         clfp_pkg::PH_LABEL: begin
            if (mdl_chars < LBL_MAX) begin
               mdl_label_chars[slot*LBL_MAX + mdl_chars] = b;
               mdl_chars++;
            end
            if (mdl_label_left > 0) mdl_label_left--;
            if (mdl_label_left == 0) finish_contact();
         end
         default: begin
            if (mdl_chars < FTR_MAX) begin
               mdl_footer_chars[shadow*FTR_MAX + mdl_chars] = b;
               mdl_chars++;
            end
         end
      endcase
   endfunction

   // one transaction in, the response it should produce out
   function automatic clfp_pkg::rsp_type predict_response(logic op, logic [7:0] b,
                                                          logic last, logic [3:0] ei,
                                                          logic [4:0] ci);
      clfp_pkg::rsp_type r;
      int unsigned slot;
      r = '0;
      if (op == OP_PUSH) begin
         if (mdl_byte_count >= 255) mdl_overlong = 1;
         else mdl_byte_count++;
         if (!mdl_overlong) parse_byte(b);
         if (last) begin
            if (mdl_overlong) r.frame_status = clfp_pkg::ST_TOO_LONG;
            else if (mdl_phase != clfp_pkg::PH_FOOTER) r.frame_status = clfp_pkg::ST_TRUNCATED;
            else begin
               mdl_bank_count[!mdl_bank] = 4'(mdl_declared);
               mdl_footer_len[!mdl_bank] = 5'(mdl_chars);
               mdl_bank  = !mdl_bank;
               mdl_valid = 1;
               r.frame_status = clfp_pkg::ST_ACCEPTED;
            end
            restart_parser();
         end
      end else if (ei < mdl_bank_count[mdl_bank] && ei < NCON) begin
         slot = mdl_bank * NCON + ei;
         r.bearing       = mdl_records[slot][0];
         r.range_value   = mdl_records[slot][1];
         r.contact_flags = mdl_records[slot][2];
         r.text_length   = 5'(mdl_label_len[slot]);
         if (ci < mdl_label_len[slot] && ci < LBL_MAX)
            r.text_char = mdl_label_chars[slot*LBL_MAX + ci];
      end else if (ei == NCON) begin
         r.text_length = mdl_footer_len[mdl_bank];
         if (ci < mdl_footer_len[mdl_bank] && ci < FTR_MAX)
            r.text_char = mdl_footer_chars[mdl_bank*FTR_MAX + ci];
      end
      r.set_valid     = mdl_valid;
      r.contact_count = mdl_bank_count[mdl_bank];
      return r;
   endfunction

   // ---------------------------------------------------------------- sender
   task automatic sender_gap();
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // one request transaction, held until the queue takes it
   task automatic send_item(logic op, logic [7:0] b, logic last, logic [3:0] ei,
                            logic [4:0] ci);
      sender_gap();
      req_push        <= 1'b1;
      req_op          <= op;
      req_data_byte   <= b;
      req_last_byte   <= last;
      req_entry_index <= ei;
      req_char_index  <= ci;
      do @(posedge clock); while (req_full);
      expected_rsps.push_back(predict_response(op, b, last, ei, ci));
   endtask

   task automatic send_read(int unsigned ei, int unsigned ci);
      send_item(OP_READ, 8'($urandom), 1'($urandom), 4'(ei), 5'(ci));
   endtask

   // pushes frame_bytes, the last one flagged; entry and char index are noise
   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++)
         send_item(OP_PUSH, frame_bytes[i], i == frame_bytes.size() - 1,
                   4'($urandom), 5'($urandom));
      frame_bytes.delete();
   endtask

   // builds a well formed frame: count byte, contacts, footer
   task automatic build_frame(int unsigned count, int unsigned max_label,
                              int unsigned footer_len);
      int unsigned n, len;
      frame_bytes.push_back(8'(count));
      n = (count > NCON) ? NCON : count;
      for (int c = 0; c < n; c++) begin
         repeat (clfp_pkg::HEADER_BYTES) frame_bytes.push_back(8'($urandom));
         len = $urandom_range(0, max_label);
         frame_bytes.push_back(8'(len));
         repeat (len) frame_bytes.push_back(8'($urandom));
      end
      repeat (footer_len) frame_bytes.push_back(8'($urandom));
   endtask

   task automatic read_some(int unsigned n);
      repeat (n) send_read($urandom_range(0, 15), $urandom_range(0, 31));
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- checker
   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   int stall_left = 0;

   always @(posedge clock) begin
      clfp_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("testbench: errors");
         $finish;
      end
      if (!reset) begin
         // a transaction completes on pop with a response waiting
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_frame_status !== want.frame_status)
                  report_mismatch("frame_status", rsp_frame_status, want.frame_status);
               if (rsp_set_valid !== want.set_valid)
                  report_mismatch("set_valid", rsp_set_valid, want.set_valid);
               if (rsp_contact_count !== want.contact_count)
                  report_mismatch("contact_count", rsp_contact_count, want.contact_count);
               if (rsp_bearing !== want.bearing)
                  report_mismatch("bearing", rsp_bearing, want.bearing);
               if (rsp_range_value !== want.range_value)
                  report_mismatch("range_value", rsp_range_value, want.range_value);
               if (rsp_contact_flags !== want.contact_flags)
                  report_mismatch("contact_flags", rsp_contact_flags, want.contact_flags);
               if (rsp_text_length !== want.text_length)
                  report_mismatch("text_length", rsp_text_length, want.text_length);
               if (rsp_text_char !== want.text_char)
                  report_mismatch("text_char", rsp_text_char, want.text_char);
            end
         end
         // receiver stalls in bursts
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_pop    <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            rsp_pop    <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_reads_after_reset();
      send_read(0, 0);
      send_read(NCON, 31);
      send_read(15, 5);
   endtask

   task automatic test_full_frames();
      // widest frame that fits: all contacts, long labels cut, long footer cut
      build_frame(NCON, 20, 40);
      send_frame();
      send_read(0, 0);
      send_read(NCON - 1, LBL_MAX - 1);
      send_read(NCON - 1, 31);
      send_read(NCON, FTR_MAX - 1);
      send_read(NCON + 1, 0);
      // clamped count, then zero contacts with empty footer
      build_frame(255, 3, 2);
      send_frame();
      build_frame(0, 0, 0);
      send_frame();
      send_read(0, 0);
      send_read(NCON, 0);
      // ends right after its last label
      build_frame(2, 4, 0);
      send_frame();
      send_read(1, 0);
   endtask

   task automatic test_truncation();
      // stops mid header, mid label, and before a contact started
      frame_bytes = '{8'd1, 8'd10, 8'd20};
      send_frame();
      frame_bytes = '{8'd1, 8'd10, 8'd20, 8'd30, 8'd5, 8'h41};
      send_frame();
      frame_bytes = '{8'd2, 8'd1, 8'd2, 8'd3, 8'd0};
      send_frame();
      frame_bytes = '{8'd3};
      send_frame();
      send_read(0, 0);
   endtask

   task automatic test_overlong();
      // too long beats truncation; the next frame parses normally
      frame_bytes.push_back(8'(NCON));
      repeat (299) frame_bytes.push_back(8'($urandom));
      send_frame();
      build_frame(1, 2, 40);
      send_frame();
      send_read(NCON, 3);
      wait_drained();
   endtask

   task automatic test_random(int unsigned items);
      int unsigned sent;
      int unsigned pick;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) build_frame($urandom_range(0, 9), $urandom_range(0, 17),
                                    $urandom_range(0, 34));
         else if (pick < 15) begin
            build_frame($urandom_range(1, NCON), 6, 0);
            frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 1)];
         end else if (pick < 16) begin
            repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom));
         end
         sent += frame_bytes.size();
         send_frame();
         pick = $urandom_range(1, 8);
         read_some(pick);
         sent += pick;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reads_after_reset();
      test_full_frames();
      test_truncation();
      test_overlong();
      test_random(450);
      // sender holds off until everything is back
      wait_drained();
      test_random(100);
      idle_enable = 1'b0;
      test_random(210);
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      restart_parser();
      mdl_bank  = 0;
      mdl_valid = 0;
      mdl_footer_len = '{default: '0};
      mdl_bank_count = '{default: '0};
   end

endmodule

// File: files.f
rtl/clfp_pkg.sv
rtl/clfp_fifo.sv
rtl/clfp_front.sv
rtl/clfp_back.sv
rtl/contact_list_frame_parser.sv
tb/testbench.sv
